@@ hw/rtl/two_channel_countdown_timer_macros.svh @@
// Assertion macros used by the countdown timer top level.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TWO_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH
`define TWO_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH

// Same-cycle implication.
`define TCCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/tcct_pkg.sv @@
// Types and constants for the two-channel countdown timer.
// No dependencies; used by tcct_chan and two_channel_countdown_timer.
`default_nettype none

package tcct_pkg;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Register word map
	localparam logic [3:0] REG_IRQ_EN  = 4'd0;
	localparam logic [3:0] REG_STATUS  = 4'd1;
	localparam logic [3:0] REG_CH0_CTL = 4'd4;
	localparam logic [3:0] REG_CH0_IVL = 4'd5;
	localparam logic [3:0] REG_CH0_CUR = 4'd6;
	localparam logic [3:0] REG_CH1_CTL = 4'd8;
	localparam logic [3:0] REG_CH1_IVL = 4'd9;
	localparam logic [3:0] REG_CH1_CUR = 4'd10;

	// Control word bits
	localparam int CTL_ENABLE_BIT = 0;
	localparam int CTL_RELOAD_BIT = 1;
	localparam int CTL_SINGLE_BIT = 7;

	localparam int NUM_CH = 2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  word_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_line;
	} rsp_t;

	// Per-channel update strobes, valid for the one cycle the request commits
	typedef struct packed {
		logic        tick;
		logic        wr_ctl;
		logic        wr_ivl;
		logic        wr_cur;
		logic [31:0] wdata;
	} chan_cmd_t;

	typedef struct packed {
		logic [7:0]  ctl;
		logic [31:0] ivl_lo;
		logic [31:0] cur_lo;
	} chan_view_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcct_chan.sv @@
// One countdown channel: control word, interval and current count.
// Depends on tcct_pkg.
`default_nettype none

module tcct_chan #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tcct_pkg::chan_cmd_t   cmd,
	output tcct_pkg::chan_view_t  view,
	output logic                  hit
);

	logic [7:0]             ctl_q;
	logic [COUNT_WIDTH-1:0] ivl_q;
	logic [COUNT_WIDTH-1:0] cur_q;

	logic [COUNT_WIDTH-1:0] cur_dec;
	logic [COUNT_WIDTH-1:0] wdata_cnt;
	logic [7:0]             ctl_wr;
	logic                   tick_live;

	always_comb begin
		cur_dec   = cur_q - COUNT_WIDTH'(1);
		wdata_cnt = COUNT_WIDTH'({32'b0, cmd.wdata});
		ctl_wr    = cmd.wdata[7:0];
		ctl_wr[tcct_pkg::CTL_RELOAD_BIT] = 1'b0;
		// a zero count holds still even when enabled
		tick_live = cmd.tick & ctl_q[tcct_pkg::CTL_ENABLE_BIT] & (cur_q != '0);
		hit       = tick_live & (cur_dec == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			ivl_q <= '0;
			cur_q <= '0;
		end else begin
			if (cmd.wr_ctl) begin
				ctl_q <= ctl_wr;
			end
			if (cmd.wr_ivl) begin
				ivl_q <= wdata_cnt;
			end
			if (tick_live) begin
				cur_q <= (hit && !ctl_q[tcct_pkg::CTL_SINGLE_BIT]) ? ivl_q : cur_dec;
			end else if (cmd.wr_cur) begin
				cur_q <= wdata_cnt;
			end else if (cmd.wr_ctl && cmd.wdata[tcct_pkg::CTL_RELOAD_BIT]) begin
				cur_q <= ivl_q;
			end
		end
	end

	assign view.ctl    = ctl_q;
	assign view.ivl_lo = 32'(ivl_q);
	assign view.cur_lo = 32'(cur_q);

endmodule

`default_nettype wire

@@ hw/rtl/two_channel_countdown_timer.sv @@
// Two-channel register-mapped countdown timer, top level.
// Depends on tcct_pkg, tcct_chan and two_channel_countdown_timer_macros.svh.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+--------------------------------------
//   request | req_valid | req_ready | req (mode, word_index, write_data)
//   result  | rsp_valid | rsp_ready | rsp (read_data, irq_line)
//
// A request waits in the input register until the result register is free or draining,
// then commits to the register file and result register in the same edge. One request
// per cycle is sustained unless stalled. A stalled result holds the result register; the
// input register takes one more request. Reset clears both valid bits, timer and IRQ regs.
`default_nettype none

`include "two_channel_countdown_timer_macros.svh"

module two_channel_countdown_timer #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  tcct_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output tcct_pkg::rsp_t rsp
);

	logic           vld_s1;
	tcct_pkg::req_t req_s1;
	logic           rsp_valid_q;
	tcct_pkg::rsp_t rsp_q;

	logic [1:0] irq_en_q;
	logic [1:0] irq_sts_q;

	logic adv;
	logic is_tick;
	logic is_read;
	logic is_write;

	tcct_pkg::chan_cmd_t  cmd  [tcct_pkg::NUM_CH];
	tcct_pkg::chan_view_t view [tcct_pkg::NUM_CH];
	logic [1:0]           hit;

	logic [1:0]  irq_en_nxt;
	logic [1:0]  irq_sts_nxt;
	logic [31:0] rd_data;

	// commit when the result register is free or being drained
	assign adv       = vld_s1 & (~rsp_valid_q | rsp_ready);
	assign req_ready = ~vld_s1 | adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_tick  = adv & (req_s1.mode == tcct_pkg::MODE_TICK);
	assign is_read  = req_s1.mode == tcct_pkg::MODE_READ;
	assign is_write = adv & (req_s1.mode == tcct_pkg::MODE_WRITE);

	always_comb begin
		cmd[0].tick   = is_tick;
		cmd[0].wr_ctl = is_write & (req_s1.word_index == tcct_pkg::REG_CH0_CTL);
		cmd[0].wr_ivl = is_write & (req_s1.word_index == tcct_pkg::REG_CH0_IVL);
		cmd[0].wr_cur = is_write & (req_s1.word_index == tcct_pkg::REG_CH0_CUR);
		cmd[0].wdata  = req_s1.write_data;
		cmd[1].tick   = is_tick;
		cmd[1].wr_ctl = is_write & (req_s1.word_index == tcct_pkg::REG_CH1_CTL);
		cmd[1].wr_ivl = is_write & (req_s1.word_index == tcct_pkg::REG_CH1_IVL);
		cmd[1].wr_cur = is_write & (req_s1.word_index == tcct_pkg::REG_CH1_CUR);
		cmd[1].wdata  = req_s1.write_data;
	end

	for (genvar c = 0; c < tcct_pkg::NUM_CH; c++) begin : g_ch
		tcct_chan #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_chan (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd[c]),
			.view  (view[c]),
			.hit   (hit[c])
		);
	end

	always_comb begin
		irq_en_nxt  = irq_en_q;
		irq_sts_nxt = irq_sts_q | hit;
		if (is_write && req_s1.word_index == tcct_pkg::REG_IRQ_EN) begin
			irq_en_nxt = req_s1.write_data[1:0];
		end
		if (is_write && req_s1.word_index == tcct_pkg::REG_STATUS) begin
			irq_sts_nxt = irq_sts_q & ~req_s1.write_data[1:0];
		end
	end

	always_comb begin
		rd_data = '0;
		if (is_read) begin
			case (req_s1.word_index)
				tcct_pkg::REG_IRQ_EN:  rd_data = {30'b0, irq_en_q};
				tcct_pkg::REG_STATUS:  rd_data = {30'b0, irq_sts_q};
				tcct_pkg::REG_CH0_CTL: rd_data = {24'b0, view[0].ctl};
				tcct_pkg::REG_CH0_IVL: rd_data = view[0].ivl_lo;
				tcct_pkg::REG_CH0_CUR: rd_data = view[0].cur_lo;
				tcct_pkg::REG_CH1_CTL: rd_data = {24'b0, view[1].ctl};
				tcct_pkg::REG_CH1_IVL: rd_data = view[1].ivl_lo;
				tcct_pkg::REG_CH1_CUR: rd_data = view[1].cur_lo;
				default:               rd_data = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			irq_en_q    <= '0;
			irq_sts_q   <= '0;
		end else begin
			vld_s1      <= (req_valid & req_ready) | (vld_s1 & ~adv);
			rsp_valid_q <= adv | (rsp_valid_q & ~rsp_ready);
			if (adv) begin
				irq_en_q  <= irq_en_nxt;
				irq_sts_q <= irq_sts_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_q.read_data <= rd_data;
			rsp_q.irq_line  <= |(irq_en_nxt & irq_sts_nxt);
		end
	end

	`TCCT_ASSERT_NEXT(a_commit_shows, adv, rsp_valid_q, "committed request produced no result")
	`TCCT_ASSERT_NEXT(a_irq_match, adv, rsp_q.irq_line == |(irq_en_q & irq_sts_q), "irq mismatch")
	`TCCT_ASSERT_NEXT(a_nonread_zero, adv && req_s1.mode != tcct_pkg::MODE_READ, rsp_q.read_data == 32'd0, "nonzero data on non-read")
	`TCCT_ASSERT_NOW(a_status_tick_only, !(adv && req_s1.mode == tcct_pkg::MODE_TICK), hit == 2'b00, "status hit without tick")

endmodule

`default_nettype wire
